>>> hw/rtl/fwps_pkg.sv
// ----------------------------------------------------------------------------
// fwps_pkg
// Shared types and sizes for the flash write request splitter: field widths,
// flash geometry, command codes and the control/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package fwps_pkg;

  // flash geometry (powers of two)
  localparam int SECTOR_BYTES = 4096;
  localparam int PAGE_BYTES   = 256;
  localparam int MAX_LEN      = 4096;

  localparam int ADDR_W = 24;
  localparam int LEN_W  = 13;
  localparam int OFF_W  = 12;
  localparam int CNT_W  = 9;
  localparam int CMD_W  = 2;

  localparam int SEC_W  = $clog2(SECTOR_BYTES);
  localparam int PAGE_W = $clog2(PAGE_BYTES);
  localparam int SIDX_W = ADDR_W - SEC_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_ERASE   = 2'd0,
    CMD_PROGRAM = 2'd1,
    CMD_REJECT  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REJECT,
    ST_ERASE,
    ST_PROGRAM
  } state_e;

  typedef struct packed {
    logic load;
    logic emit_reject;
    logic emit_erase;
    logic emit_program;
  } dp_cmd_t;

  typedef struct packed {
    logic reject;
    logic erase_pending;
    logic chunk_last;
  } dp_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/fwps_dp.sv
// ----------------------------------------------------------------------------
// fwps_dp
// Datapath: request cursors, range check, page chunking and the registered
// command word.
// ----------------------------------------------------------------------------
`default_nettype none

module fwps_dp import fwps_pkg::*; (
  input  logic              clk_i,
  input  logic [ADDR_W-1:0] start_address_i,
  input  logic [LEN_W-1:0]  length_i,
  input  dp_cmd_t           cmd_i,
  output dp_status_t        status_o,
  output logic [CMD_W-1:0]  command_o,
  output logic [ADDR_W-1:0] flash_address_o,
  output logic [OFF_W-1:0]  buffer_offset_o,
  output logic [CNT_W-1:0]  byte_count_o,
  output logic              last_o
);

  logic [SIDX_W:0]   erase_sec_q,  erase_sec_d;
  logic [SIDX_W-1:0] end_sec_q,    end_sec_d;
  logic [ADDR_W-1:0] write_cur_q,  write_cur_d;
  logic [LEN_W-1:0]  bytes_left_q, bytes_left_d;
  logic [LEN_W-1:0]  data_off_q,   data_off_d;

  cmd_e              out_cmd_q,    out_cmd_d;
  logic [ADDR_W-1:0] out_addr_q,   out_addr_d;
  logic [OFF_W-1:0]  out_off_q,    out_off_d;
  logic [CNT_W-1:0]  out_cnt_q,    out_cnt_d;
  logic              out_last_q,   out_last_d;

  logic [ADDR_W:0]   end_addr;
  logic              aligned;
  logic [CNT_W-1:0]  room;
  logic              left_lt_room;
  logic [CNT_W-1:0]  chunk;
  logic [LEN_W-1:0]  chunk_ext;

  // range check on the incoming request
  assign end_addr = {1'b0, start_address_i} + (ADDR_W+1)'(length_i) - (ADDR_W+1)'(1);
  assign aligned  = (start_address_i[SEC_W-1:0] == '0);

  assign status_o.reject = (length_i == '0) || (length_i > LEN_W'(MAX_LEN)) ||
                           end_addr[ADDR_W];
  assign status_o.erase_pending = (erase_sec_q <= {1'b0, end_sec_q});

  // page chunking
  assign room         = CNT_W'(PAGE_BYTES) - {1'b0, write_cur_q[PAGE_W-1:0]};
  assign left_lt_room = (bytes_left_q < {{(LEN_W-CNT_W){1'b0}}, room});
  assign chunk        = left_lt_room ? bytes_left_q[CNT_W-1:0] : room;
  assign chunk_ext    = {{(LEN_W-CNT_W){1'b0}}, chunk};
  assign status_o.chunk_last = (bytes_left_q <= {{(LEN_W-CNT_W){1'b0}}, room});

  always_comb begin
    erase_sec_d  = erase_sec_q;
    end_sec_d    = end_sec_q;
    write_cur_d  = write_cur_q;
    bytes_left_d = bytes_left_q;
    data_off_d   = data_off_q;
    out_cmd_d    = out_cmd_q;
    out_addr_d   = out_addr_q;
    out_off_d    = out_off_q;
    out_cnt_d    = out_cnt_q;
    out_last_d   = out_last_q;

    if (cmd_i.load) begin
      // an aligned start erases its own sector first
      erase_sec_d  = {1'b0, start_address_i[ADDR_W-1:SEC_W]} +
                     (SIDX_W+1)'(!aligned);
      end_sec_d    = end_addr[ADDR_W-1:SEC_W];
      write_cur_d  = start_address_i;
      bytes_left_d = length_i;
      data_off_d   = '0;
    end

    if (cmd_i.emit_reject) begin
      out_cmd_d  = CMD_REJECT;
      out_addr_d = write_cur_q;
      out_off_d  = '0;
      out_cnt_d  = '0;
      out_last_d = 1'b1;
    end

    if (cmd_i.emit_erase) begin
      out_cmd_d   = CMD_ERASE;
      out_addr_d  = {erase_sec_q[SIDX_W-1:0], {SEC_W{1'b0}}};
      out_off_d   = '0;
      out_cnt_d   = '0;
      out_last_d  = 1'b0;
      erase_sec_d = erase_sec_q + (SIDX_W+1)'(1);
    end

    if (cmd_i.emit_program) begin
      out_cmd_d    = CMD_PROGRAM;
      out_addr_d   = write_cur_q;
      out_off_d    = data_off_q[OFF_W-1:0];
      out_cnt_d    = chunk;
      out_last_d   = status_o.chunk_last;
      write_cur_d  = write_cur_q + {{(ADDR_W-CNT_W){1'b0}}, chunk};
      bytes_left_d = bytes_left_q - chunk_ext;
      data_off_d   = data_off_q + chunk_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    erase_sec_q  <= erase_sec_d;
    end_sec_q    <= end_sec_d;
    write_cur_q  <= write_cur_d;
    bytes_left_q <= bytes_left_d;
    data_off_q   <= data_off_d;
    out_cmd_q    <= out_cmd_d;
    out_addr_q   <= out_addr_d;
    out_off_q    <= out_off_d;
    out_cnt_q    <= out_cnt_d;
    out_last_q   <= out_last_d;
  end

  assign command_o       = out_cmd_q;
  assign flash_address_o = out_addr_q;
  assign buffer_offset_o = out_off_q;
  assign byte_count_o    = out_cnt_q;
  assign last_o          = out_last_q;

endmodule

`default_nettype wire

>>> hw/rtl/fwps_ctrl.sv
// ----------------------------------------------------------------------------
// fwps_ctrl
// Controller: walks a request through reject, erase and program phases and
// owns the handshakes and the output word valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module fwps_ctrl import fwps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;
  logic   emit;

  assign slot_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.reject ? ST_REJECT : ST_ERASE;
        end
      end
      ST_REJECT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_ERASE: begin
        if (!status_i.erase_pending) begin
          state_d = ST_PROGRAM;
        end
      end
      ST_PROGRAM: begin
        if (slot_free && status_i.chunk_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_REJECT:  cmd_o.emit_reject  = slot_free;
      ST_ERASE:   cmd_o.emit_erase   = slot_free && status_i.erase_pending;
      ST_PROGRAM: cmd_o.emit_program = slot_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign emit = cmd_o.emit_reject || cmd_o.emit_erase || cmd_o.emit_program;

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> hw/rtl/flash_write_erase_page_splitter.sv
// first word: registered from ERASE or REJECT once a request is taken;
//   when no sector erase leads, ERASE moves on and PROGRAM registers it
// one request at a time; each yields its sector erases, then its page
//   chunks; a rejected request yields a single reject word
// the sequencer emits at most one word per cycle and waits on output stalls
// reset: asynchronous, active low; returns to idle with no word pending
// ----------------------------------------------------------------------------
// flash_write_erase_page_splitter
// Splits a flash write request into sector erases followed by page-program
// chunks that never cross a page boundary, or into one reject word.
// ----------------------------------------------------------------------------
`default_nettype none

module flash_write_erase_page_splitter import fwps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ADDR_W-1:0] start_address_i,
  input  logic [LEN_W-1:0]  length_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CMD_W-1:0]  command_o,
  output logic [ADDR_W-1:0] flash_address_o,
  output logic [OFF_W-1:0]  buffer_offset_o,
  output logic [CNT_W-1:0]  byte_count_o,
  output logic              last_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  fwps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  fwps_dp u_dp (
    .clk_i           (clk_i),
    .start_address_i (start_address_i),
    .length_i        (length_i),
    .cmd_i           (dp_cmd),
    .status_o        (dp_status),
    .command_o       (command_o),
    .flash_address_o (flash_address_o),
    .buffer_offset_o (buffer_offset_o),
    .byte_count_o    (byte_count_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire

>>> hw/rtl/fwps_checker.sv
// ----------------------------------------------------------------------------
// fwps_checker
// Port-level checks for the flash write request splitter.
// ----------------------------------------------------------------------------
`default_nettype none

module fwps_checker import fwps_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [CMD_W-1:0]  command_o,
  input logic [ADDR_W-1:0] flash_address_o,
  input logic [OFF_W-1:0]  buffer_offset_o,
  input logic [CNT_W-1:0]  byte_count_o,
  input logic              last_o
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(command_o) &&
    $stable(flash_address_o) && $stable(buffer_offset_o) &&
    $stable(byte_count_o) && $stable(last_o))
    else $error("output word changed while stalled");

  // busy right after taking a request
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  a_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (command_o == CMD_REJECT) |-> last_o && (byte_count_o == '0))
    else $error("bad reject word");

  a_erase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (command_o == CMD_ERASE) |->
      !last_o && (byte_count_o == '0) && (flash_address_o[SEC_W-1:0] == '0))
    else $error("bad erase word");

  // program chunk stays within one page
  a_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (command_o == CMD_PROGRAM) |-> (byte_count_o != '0) &&
      (({2'b00, flash_address_o[PAGE_W-1:0]} + {1'b0, byte_count_o}) <=
       (CNT_W+1)'(PAGE_BYTES)))
    else $error("program chunk crosses a page");

endmodule

bind flash_write_erase_page_splitter fwps_checker u_fwps_checker (.*);

`default_nettype wire

>>> tb/flash_write_erase_page_splitter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flash_write_erase_page_splitter_tb
// Drives write requests into the splitter and compares every command word it
// emits against a behavioural prediction of the erase and page-program walk.
// Directed corner requests come first, then random requests with bursty input
// and a stalling receiver.
// ----------------------------------------------------------------------------

module flash_write_erase_page_splitter_tb;
  import fwps_pkg::*;

  localparam int          CLK_HALF     = 5;
  localparam int          RESET_CYCLES = 7;
  localparam int          RANDOM_ITEMS = 240;
  localparam int          LONG_HOLD    = 300;
  localparam int          SETTLE       = 20;
  localparam int          TIMEOUT_NS   = 5_000_000;
  localparam int unsigned ADDR_TOP     = (1 << ADDR_W) - 1;
  localparam int          PRINT_CAP    = 30;

  typedef struct packed {
    cmd_e              command;
    logic [ADDR_W-1:0] flash_address;
    logic [OFF_W-1:0]  buffer_offset;
    logic [CNT_W-1:0]  byte_count;
    logic              last;
  } flash_word_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [ADDR_W-1:0] start_address_i;
  logic [LEN_W-1:0]  length_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [CMD_W-1:0]  command_o;
  logic [ADDR_W-1:0] flash_address_o;
  logic [OFF_W-1:0]  buffer_offset_o;
  logic [CNT_W-1:0]  byte_count_o;
  logic              last_o;

  bit hold_off_req = 1'b0;

  flash_write_erase_page_splitter DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .start_address_i (start_address_i),
    .length_i        (length_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .command_o       (command_o),
    .flash_address_o (flash_address_o),
    .buffer_offset_o (buffer_offset_o),
    .byte_count_o    (byte_count_o),
    .last_o          (last_o)
  );

  class flash_cmd_scoreboard;
    flash_word_t expected_words[$];
    int unsigned errors;
    int unsigned erase_cursor, end_sector, write_cursor, bytes_left, data_offset;

    function new();
      errors       = 0;
      erase_cursor = 0;
      end_sector   = 0;
      write_cursor = 0;
      bytes_left   = 0;
      data_offset  = 0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void report_mismatch(string msg);
      if (errors < PRINT_CAP) begin
        $display("%0t mismatch: %s", $realtime, msg);
      end
      errors++;
    endfunction

    function void queue_word(cmd_e cmd, int unsigned addr, int unsigned off,
                             int unsigned cnt, bit is_last);
      flash_word_t w;
      w.command       = cmd;
      w.flash_address = addr[ADDR_W-1:0];
      w.buffer_offset = off[OFF_W-1:0];
      w.byte_count    = cnt[CNT_W-1:0];
      w.last          = is_last;
      expected_words.push_back(w);
    endfunction

    // walk one request: reject word, or erases then page-bounded program chunks
    function void note_request(logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len);
      int unsigned a, n, last_byte, room, chunk;
      a = 32'(addr);
      n = 32'(len);
      if (n == 0 || n > MAX_LEN || a + n - 1 > ADDR_TOP) begin
        queue_word(CMD_REJECT, a, 0, 0, 1'b1);
        return;
      end
      last_byte = a + n - 1;
      // start sector only erased when the write begins on its boundary
      if (a % SECTOR_BYTES == 0) begin
        queue_word(CMD_ERASE, a, 0, 0, 1'b0);
      end
      erase_cursor = (a / SECTOR_BYTES) * SECTOR_BYTES + SECTOR_BYTES;
      end_sector   = (last_byte / SECTOR_BYTES) * SECTOR_BYTES;
      while (erase_cursor <= end_sector) begin
        queue_word(CMD_ERASE, erase_cursor, 0, 0, 1'b0);
        erase_cursor += SECTOR_BYTES;
      end
      write_cursor = a;
      bytes_left   = n;
      data_offset  = 0;
      while (bytes_left != 0) begin
        room  = PAGE_BYTES - write_cursor % PAGE_BYTES;
        chunk = (bytes_left < room) ? bytes_left : room;
        queue_word(CMD_PROGRAM, write_cursor, data_offset, chunk, chunk == bytes_left);
        bytes_left  -= chunk;
        data_offset  = (data_offset + chunk) & 32'h1FFF;
        write_cursor = (write_cursor + chunk) & ADDR_TOP;
      end
    endfunction

    function void check_word(flash_word_t got);
      flash_word_t want;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word cmd %0d addr %h", got.command,
                                  got.flash_address));
        return;
      end
      want = expected_words.pop_front();
      if (got.command !== want.command)
        report_mismatch($sformatf("command %0d, want %0d (addr %h)", got.command,
                                  want.command, want.flash_address));
      if (got.flash_address !== want.flash_address)
        report_mismatch($sformatf("flash_address %h, want %h", got.flash_address,
                                  want.flash_address));
      if (got.buffer_offset !== want.buffer_offset)
        report_mismatch($sformatf("buffer_offset %0d, want %0d (addr %h)",
                                  got.buffer_offset, want.buffer_offset,
                                  want.flash_address));
      if (got.byte_count !== want.byte_count)
        report_mismatch($sformatf("byte_count %0d, want %0d (addr %h)", got.byte_count,
                                  want.byte_count, want.flash_address));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %b, want %b (addr %h)", got.last, want.last,
                                  want.flash_address));
    endfunction
  endclass

  flash_cmd_scoreboard sb;

  always #(CLK_HALF) clk_i = ~clk_i;

  // input and output monitors
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && in_valid_i && in_ready_o === 1'b1) begin
      sb.note_request(start_address_i, length_i);
    end
  end

  always @(posedge clk_i) begin
    flash_word_t got;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i) begin
      got.command       = cmd_e'(command_o);
      got.flash_address = flash_address_o;
      got.buffer_offset = buffer_offset_o;
      got.byte_count    = byte_count_o;
      got.last          = last_o;
      sb.check_word(got);
    end
  end

  // receiver: stall pattern picked per span, plus one long hold on request
  initial begin : receiver
    int mode, span, k;
    out_ready_i = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 80);
      for (k = 0; k < span; k++) begin
        @(posedge clk_i);
        if (hold_off_req) begin
          out_ready_i <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk_i);
          hold_off_req = 1'b0;
        end else begin
          case (mode)
            0: out_ready_i <= 1'b1;
            1: out_ready_i <= 1'($urandom_range(0, 1));
            2: out_ready_i <= ($urandom_range(0, 3) == 0);
            default: out_ready_i <= (k % 4 != 0);
          endcase
        end
      end
    end
  end

  task automatic send_request(input logic [ADDR_W-1:0] addr,
                              input logic [LEN_W-1:0] len);
    in_valid_i      <= 1'b1;
    start_address_i <= addr;
    length_i        <= len;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
  endtask

  task automatic idle_cycles(input int n);
    in_valid_i      <= 1'b0;
    start_address_i <= ADDR_W'($urandom);
    length_i        <= LEN_W'($urandom);
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic void random_request(output logic [ADDR_W-1:0] addr,
                                         output logic [LEN_W-1:0] len);
    int unsigned pick, n;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      // mostly well-formed and short, some aligned starts
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_LEN) : $urandom_range(1, 600);
      addr = ADDR_W'($urandom_range(0, ADDR_TOP - n + 1));
      case ($urandom_range(0, 4))
        0: addr = addr & ~ADDR_W'(SECTOR_BYTES - 1);
        1: addr = addr & ~ADDR_W'(PAGE_BYTES - 1);
        2: addr = (addr & ~ADDR_W'(SECTOR_BYTES - 1)) |
                  ADDR_W'(SECTOR_BYTES - $urandom_range(1, 16));
        default: ;
      endcase
      len = LEN_W'(n);
    end else if (pick < 75) begin
      n    = $urandom_range(MAX_LEN / 2 + 1, MAX_LEN);
      addr = ADDR_W'($urandom_range(0, ADDR_TOP - n + 1));
      len  = LEN_W'(n);
    end else if (pick < 85) begin
      // near the top of the address space, either side of the limit
      addr = ADDR_W'(ADDR_TOP - $urandom_range(0, 5000));
      len  = LEN_W'($urandom_range(1, MAX_LEN));
    end else if (pick < 93) begin
      addr = ADDR_W'($urandom);
      len  = ($urandom_range(0, 2) == 0) ? 13'd0 :
             LEN_W'($urandom_range(MAX_LEN + 1, 8191));
    end else begin
      addr = ADDR_W'($urandom);
      len  = LEN_W'($urandom);
    end
  endfunction

  initial begin : timeout
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int i, burst;
    bit held, paused;
    logic [ADDR_W-1:0] a;
    logic [LEN_W-1:0] l;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    start_address_i = '0;
    length_i        = '0;
    held            = 1'b0;
    paused          = 1'b0;
    sb              = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners: extremes, rejects, page and sector crossings
    send_request(24'h000000, 13'd1);
    send_request(24'h000000, 13'd4096);
    send_request(24'hFFFFFF, 13'd1);
    send_request(24'hFFFFFF, 13'd2);
    send_request(24'hFFF000, 13'd4096);
    send_request(24'hFFF001, 13'd4096);
    send_request(24'h123456, 13'd0);
    send_request(24'h000000, 13'd4097);
    send_request(24'hABCDEF, 13'd8191);
    send_request(24'h0000FF, 13'd2);
    send_request(24'h000FFF, 13'd2);
    send_request(24'h000801, 13'd4096);
    send_request(24'h001000, 13'd256);
    send_request(24'h002100, 13'd256);
    send_request(24'h003F00, 13'd512);
    send_request(24'h555555, 13'd4096);
    send_request(24'hAAAAAA, 13'h0AAA);
    send_request(24'h7FF000, 13'd1);
    send_request(24'h000001, 13'd4095);
    send_request(24'hFFFF00, 13'd256);
    send_request(24'hFFFF01, 13'd256);
    send_request(24'h000100, 13'h1555);
    idle_cycles(3);

    i = 0;
    while (i < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 10);
      if (i >= 60 && !held) begin
        // receiver blocks while requests keep coming
        held         = 1'b1;
        hold_off_req = 1'b1;
        burst        = 16;
      end
      repeat (burst) begin
        random_request(a, l);
        send_request(a, l);
        i++;
      end
      if (i >= 150 && !paused) begin
        paused = 1'b1;
        drain_results();
      end else if ($urandom_range(0, 3) != 0) begin
        idle_cycles($urandom_range(1, 25));
      end
    end

    drain_results();
    repeat (SETTLE) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/fwps_pkg.sv
hw/rtl/fwps_dp.sv
hw/rtl/fwps_ctrl.sv
hw/rtl/flash_write_erase_page_splitter.sv
hw/rtl/fwps_checker.sv
tb/flash_write_erase_page_splitter_tb.sv
